// File: sv/chgw_pkg.sv
// ----------------------------------------------------------------------------
// chgw_pkg
// command and status types shared by the hull walk controller and datapath
// ----------------------------------------------------------------------------
package chgw_pkg;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // store an accepted point and update the extreme trackers
        logic init;     // set up the walk from the start point
        logic capture;  // form the orientation products for the current candidate
        logic decide;   // take or skip the current candidate
        logic advance;  // close one step of the walk and emit the vertex
        logic j_inc;    // move the scan to the next stored point
        logic j_clear;  // restart the scan at point zero
    } chgw_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic j_last;     // scan index sits on the last stored point
        logic walk_done;  // the chosen target is the start point
    } chgw_status_t;

endpackage

// File: sv/chgw_ctrl.sv
// ----------------------------------------------------------------------------
// chgw_ctrl
// sequencer for point loading, the per-vertex scan and result emission
// ----------------------------------------------------------------------------
module chgw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  last,
    input  chgw_pkg::chgw_status_t status,
    output chgw_pkg::chgw_cmd_t    cmd,
    output logic                  busy
);
    import chgw_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        INIT,
        MUL,
        CMP,
        STEP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (start && last)
                begin
                    state_next = INIT;
                end
            end
            INIT:
            begin
                state_next = MUL;
            end
            MUL:
            begin
                state_next = CMP;
            end
            CMP:
            begin
                state_next = status.j_last ? STEP : MUL;
            end
            STEP:
            begin
                state_next = status.walk_done ? IDLE : MUL;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // state and registered busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != IDLE);
        end
    end

    // command decode
    always_comb
    begin
        cmd         = '0;
        cmd.load    = (state_reg == IDLE) && start;
        cmd.init    = (state_reg == INIT);
        cmd.capture = (state_reg == MUL);
        cmd.decide  = (state_reg == CMP);
        cmd.advance = (state_reg == STEP);
        cmd.j_inc   = (state_reg == CMP) && !status.j_last;
        cmd.j_clear = (state_reg == INIT) || (state_reg == STEP)
                      || ((state_reg == CMP) && status.j_last);
    end

    assign busy = busy_reg;

endmodule

// File: sv/chgw_datapath.sv
// ----------------------------------------------------------------------------
// chgw_datapath
// point memory, extreme trackers, orientation unit and walk registers
// ----------------------------------------------------------------------------
module chgw_datapath #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  chgw_pkg::chgw_cmd_t           cmd,
    input  logic signed [COORD_BITS-1:0] x,
    input  logic signed [COORD_BITS-1:0] y,
    output chgw_pkg::chgw_status_t        status,
    output logic                         valid,
    output logic [$clog2(MAX_POINTS)-1:0] point_index,
    output logic                         last_res
);
    import chgw_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int C     = COORD_BITS;
    localparam int D     = COORD_BITS + 1;
    localparam int P     = 2 * D;

    // point memory
    logic signed [C-1:0] mem_x [MAX_POINTS];
    logic signed [C-1:0] mem_y [MAX_POINTS];
    logic signed [C-1:0] rd_x_reg;
    logic signed [C-1:0] rd_y_reg;

    // control registers
    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      j_reg;
    logic [IDX_W-1:0]      j_next;
    logic [MAX_POINTS-1:0] mark_reg;
    logic                  valid_reg;

    // extreme trackers filled while loading
    logic [IDX_W-1:0]    minx_idx_reg, miny_idx_reg, maxy_idx_reg;
    logic signed [C-1:0] minx_x_reg, minx_y_reg;
    logic signed [C-1:0] miny_x_reg, miny_y_reg;
    logic signed [C-1:0] maxy_x_reg, maxy_y_reg;

    // walk registers
    logic [IDX_W-1:0]    cur_idx_reg, tgt_idx_reg, first_idx_reg;
    logic signed [C-1:0] cur_x_reg, cur_y_reg, tgt_x_reg, tgt_y_reg;
    logic signed [C-1:0] first_x_reg, first_y_reg;
    logic                first_reached_reg;
    logic [IDX_W-1:0]    cand_idx_reg;
    logic signed [C-1:0] cand_x_reg, cand_y_reg;
    logic                cand_marked_reg;
    logic signed [P-1:0] prod_p_reg, prod_q_reg;
    logic                box_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic                out_last_reg;

    logic                store_en;
    logic                first_pt;
    logic                first_is_max;
    logic signed [D-1:0] d1, d2, d3, d4;
    logic signed [C-1:0] bx_lo, bx_hi, by_lo, by_hi;
    logic                in_box;
    logic                take;
    logic                tgt_is_first;

    assign store_en = cmd.load && (count_reg < CNT_W'(MAX_POINTS));
    assign first_pt = (count_reg == '0);

    // scan index, the read address follows its next value
    always_comb
    begin
        j_next = j_reg;
        if (cmd.j_clear)
        begin
            j_next = '0;
        end
        else if (cmd.j_inc)
        begin
            j_next = j_reg + IDX_W'(1);
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem_x[count_reg[IDX_W-1:0]] <= x;
            mem_y[count_reg[IDX_W-1:0]] <= y;
        end
        rd_x_reg <= mem_x[j_next];
        rd_y_reg <= mem_y[j_next];
    end

    // orientation terms of (cur, tgt, candidate) and bounding box test
    always_comb
    begin
        d1 = D'(cur_x_reg) - D'(rd_x_reg);
        d2 = D'(cur_y_reg) - D'(rd_y_reg);
        d3 = D'(tgt_x_reg) - D'(rd_x_reg);
        d4 = D'(tgt_y_reg) - D'(rd_y_reg);
        bx_lo = (cur_x_reg < tgt_x_reg) ? cur_x_reg : tgt_x_reg;
        bx_hi = (cur_x_reg < tgt_x_reg) ? tgt_x_reg : cur_x_reg;
        by_lo = (cur_y_reg < tgt_y_reg) ? cur_y_reg : tgt_y_reg;
        by_hi = (cur_y_reg < tgt_y_reg) ? tgt_y_reg : cur_y_reg;
        in_box = (rd_x_reg >= bx_lo) && (rd_x_reg <= bx_hi)
                 && (rd_y_reg >= by_lo) && (rd_y_reg <= by_hi);
    end

    // negative turn, or collinear and on the segment
    assign take = !cand_marked_reg
                  && ((prod_p_reg < prod_q_reg)
                      || ((prod_p_reg == prod_q_reg) && box_reg));

    assign first_is_max = (miny_idx_reg == minx_idx_reg);
    assign tgt_is_first = (tgt_idx_reg == first_idx_reg);

    // control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            j_reg     <= '0;
            mark_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            j_reg     <= j_next;
            valid_reg <= cmd.advance;
            if (store_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.init)
            begin
                mark_reg[minx_idx_reg] <= 1'b1;
            end
            if (cmd.advance)
            begin
                if (status.walk_done)
                begin
                    count_reg <= '0;
                    mark_reg  <= '0;
                end
                else
                begin
                    mark_reg[tgt_idx_reg] <= 1'b1;
                end
            end
        end
    end

    // trackers, walk and output payload
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            if (first_pt || (x < minx_x_reg))
            begin
                minx_idx_reg <= count_reg[IDX_W-1:0];
                minx_x_reg   <= x;
                minx_y_reg   <= y;
            end
            if (first_pt || (y < miny_y_reg))
            begin
                miny_idx_reg <= count_reg[IDX_W-1:0];
                miny_x_reg   <= x;
                miny_y_reg   <= y;
            end
            if (first_pt || (y > maxy_y_reg))
            begin
                maxy_idx_reg <= count_reg[IDX_W-1:0];
                maxy_x_reg   <= x;
                maxy_y_reg   <= y;
            end
        end

        // walk set-up from the least-x point
        if (cmd.init)
        begin
            cur_idx_reg       <= minx_idx_reg;
            cur_x_reg         <= minx_x_reg;
            cur_y_reg         <= minx_y_reg;
            first_reached_reg <= 1'b0;
            if (first_is_max)
            begin
                first_idx_reg <= maxy_idx_reg;
                first_x_reg   <= maxy_x_reg;
                first_y_reg   <= maxy_y_reg;
                tgt_idx_reg   <= maxy_idx_reg;
                tgt_x_reg     <= maxy_x_reg;
                tgt_y_reg     <= maxy_y_reg;
            end
            else
            begin
                first_idx_reg <= miny_idx_reg;
                first_x_reg   <= miny_x_reg;
                first_y_reg   <= miny_y_reg;
                tgt_idx_reg   <= miny_idx_reg;
                tgt_x_reg     <= miny_x_reg;
                tgt_y_reg     <= miny_y_reg;
            end
        end

        // products registered ahead of the compare
        if (cmd.capture)
        begin
            prod_p_reg      <= d1 * d4;
            prod_q_reg      <= d2 * d3;
            box_reg         <= in_box;
            cand_marked_reg <= mark_reg[j_reg];
            cand_idx_reg    <= j_reg;
            cand_x_reg      <= rd_x_reg;
            cand_y_reg      <= rd_y_reg;
        end

        if (cmd.decide && take)
        begin
            tgt_idx_reg <= cand_idx_reg;
            tgt_x_reg   <= cand_x_reg;
            tgt_y_reg   <= cand_y_reg;
        end

        // emit the current vertex, then move to the chosen target
        if (cmd.advance)
        begin
            out_idx_reg  <= cur_idx_reg;
            out_last_reg <= status.walk_done;
            cur_idx_reg  <= tgt_idx_reg;
            cur_x_reg    <= tgt_x_reg;
            cur_y_reg    <= tgt_y_reg;
            first_reached_reg <= first_reached_reg || tgt_is_first;
            if (first_reached_reg || tgt_is_first)
            begin
                tgt_idx_reg <= minx_idx_reg;
                tgt_x_reg   <= minx_x_reg;
                tgt_y_reg   <= minx_y_reg;
            end
            else
            begin
                tgt_idx_reg <= first_idx_reg;
                tgt_x_reg   <= first_x_reg;
                tgt_y_reg   <= first_y_reg;
            end
        end
    end

    // status back to the controller
    always_comb
    begin
        status           = '0;
        status.j_last    = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
        status.walk_done = (tgt_idx_reg == minx_idx_reg);
    end

    assign valid       = valid_reg;
    assign point_index = out_idx_reg;
    assign last_res    = out_last_reg;

endmodule

// File: sv/convex_hull_gift_wrap.sv
// ----------------------------------------------------------------------------
// convex_hull_gift_wrap
// stores a 2-D point set and walks its boundary by gift wrapping
// ----------------------------------------------------------------------------
// channel   signals                 handshake
// point in  x, y, last              start high and busy low at a clock edge
// vertex    point_index, last_res   valid high for one cycle, no back-pressure
//
// a point without last is stored and the block stays idle; a point with last starts the walk at once
// one walk: an INIT set-up state, then per boundary vertex a MUL and a CMP state for
// each of the n stored points and a closing STEP state, a split forced by the single
// memory read port and the compare that must see the target chosen for the previous candidate
// busy stays high from the cycle after the last point until the final vertex
// reset clears the point count and the boundary marks, memory needs no clear
// ----------------------------------------------------------------------------
module convex_hull_gift_wrap #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  x,
    input  logic signed [COORD_BITS-1:0]  y,
    input  logic                          last,
    output logic                          valid,
    output logic [$clog2(MAX_POINTS)-1:0] point_index,
    output logic                          last_res
);
    import chgw_pkg::*;

    chgw_cmd_t    cmd;
    chgw_status_t status;

    // sequencer
    chgw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (last),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // storage and arithmetic
    chgw_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .x           (x),
        .y           (y),
        .status      (status),
        .valid       (valid),
        .point_index (point_index),
        .last_res    (last_res)
    );

    // the final vertex leaves the block idle
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_res |-> !busy)
        else $error("final vertex emitted while still busy");

    // an earlier vertex is always followed by more of the walk
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last_res |-> busy)
        else $error("walk stopped after a vertex without the final mark");

    // a point without last does not start a walk
    a_plain_load: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !last |=> !busy)
        else $error("walk started by a point without last");

    // vertex strobes never come back to back
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("vertex strobes in consecutive cycles");

endmodule
